>>> rtl/rtchp_pkg.sv
package rtchp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int LEN_W = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W = 3;

   localparam logic [7:0] LINK_ETHERNET = 8'd1;
   localparam logic [7:0] LINK_WIFI = 8'd105;
   localparam logic [7:0] LINK_PRISM = 8'd119;
   localparam logic [7:0] LINK_RADIOTAP = 8'd127;
   localparam logic [7:0] LINK_RESET = LINK_RADIOTAP;

   localparam logic REG_LINK_TYPE = 1'b0;

   localparam logic [31:0] PRISM_TAG = 32'h0000_0044;
   localparam int MIN_FRAME = 8;
   localparam int FCS_BYTES = 4;
   localparam int PRESENT_START = 4;

   localparam int FLAG_FCS_PRESENT = 4;
   localparam int FLAG_BAD_FCS = 6;
   localparam int PRESENT_CHAIN = 7;

   localparam logic [2:0] FIELD_FLAGS = 3'd1;
   localparam logic [2:0] FIELD_CHANNEL = 3'd3;
   localparam logic [2:0] FIELD_SIGNAL = 3'd5;
   localparam logic [2:0] FIELD_NOISE = 3'd6;

   localparam logic [15:0] FREQ_BG_LOW = 16'd2402;
   localparam logic [15:0] FREQ_BG_BASE = 16'd2412;
   localparam logic [15:0] FREQ_BG_HIGH = 16'd2472;
   localparam logic [15:0] FREQ_CH14 = 16'd2484;
   localparam logic [15:0] FREQ_A_LOW = 16'd5150;
   localparam logic [15:0] FREQ_A_HIGH = 16'd5350;
   localparam logic [15:0] FREQ_B_LOW = 16'd5470;
   localparam logic [15:0] FREQ_B_HIGH = 16'd5720;
   localparam logic [15:0] FREQ_C_HIGH = 16'd5865;

   localparam logic [7:0] CHAN_BG_BASE = 8'd1;
   localparam logic [7:0] CHAN_14 = 8'd14;
   localparam logic [7:0] CHAN_A_BASE = 8'd30;
   localparam logic [7:0] CHAN_B_BASE = 8'd94;
   localparam logic [7:0] CHAN_C_BASE = 8'd144;

   localparam logic [15:0] DIV5_RECIP = 16'd205;
   localparam int DIV5_SHIFT = 10;

   typedef enum logic [2:0] {
      ST_ETHERNET,
      ST_WIFI,
      ST_SHORT,
      ST_CORRUPT,
      ST_FCS_ERROR,
      ST_TRUNCATED,
      ST_PRISM_BAD,
      ST_UNKNOWN
   } status_type;

   typedef struct packed {
      logic [7:0]       link_type;
      logic [LEN_W-1:0] len;
      logic [31:0]      hlen;
      logic             tag_prism;
      logic             tag_low_zero;
      logic             overrun;
      logic             flags_done;
      logic             chan_seen;
      logic             sig_seen;
      logic             noise_seen;
      logic [7:0]       flag_byte;
      logic [15:0]      freq;
      logic [7:0]       sig;
      logic [7:0]       noise;
   } frame_rec_type;

   typedef struct packed {
      status_type        status;
      logic [15:0]       payload_offset;
      logic [15:0]       payload_length;
      logic signed [8:0] channel;
      logic signed [7:0] signal_dbm;
      logic signed [7:0] noise_dbm;
      logic [2:0]        unknown_flag_bits;
      logic              fcs_stripped;
   } result_type;

   function automatic logic [2:0] lowest_field(input logic [7:0] pend);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (pend[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [3:0] field_size(input logic [2:0] idx);
      logic [3:0] r;
      case (idx)
         3'd0: r = 4'd8;
         3'd3: r = 4'd4;
         3'd4: r = 4'd2;
         default: r = 4'd1;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] field_align_mask(input logic [2:0] idx);
      logic [2:0] r;
      case (idx)
         3'd0: r = 3'd7;
         3'd3: r = 3'd1;
         3'd4: r = 3'd1;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/rtchp_front.sv
module rtchp_front #(
   parameter int LENGTH_BITS = rtchp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                in_byte,
   input  logic                      in_last,
   input  logic [7:0]                link_type,
   input  logic                      queue_full,
   output logic                      push,
   output rtchp_pkg::frame_rec_type  push_rec
);

   localparam int CW = LENGTH_BITS + 1;
   localparam int XW = (CW + 1 > 33) ? CW + 1 : 33;
   localparam int LW = rtchp_pkg::LEN_W;
   localparam logic [LENGTH_BITS-1:0] MAXPOS = {LENGTH_BITS{1'b1}};

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            tag_ff, tag_in;
   logic [31:0]            hlen_ff, hlen_in;
   logic [7:0]             present_ff, present_in;
   logic [CW-1:0]          cur_ff, cur_in;
   logic                   chain_ff, chain_in;
   logic [7:0]             flag_ff, flag_in;
   logic [15:0]            freq_ff, freq_in;
   logic [7:0]             sig_ff, sig_in;
   logic [7:0]             noise_ff, noise_in;
   logic [7:0]             seen_ff, seen_in;
   logic                   over_ff, over_in;
   logic                   accept;

   assign in_ready = !queue_full;
   assign accept = in_valid && in_ready;

   always_comb begin
      logic [XW-1:0] px;
      logic [XW-1:0] cx;
      logic [XW-1:0] c4;
      logic [XW-1:0] al;
      logic [XW-1:0] s_cur;
      logic [7:0]    s_pend;
      logic          s_go;
      logic [7:0]    pend;
      logic [2:0]    fi;
      logic [3:0]    sz;
      logic [2:0]    off;
      logic [2:0]    sj;
      logic [2:0]    amask;

      tag_in = tag_ff;
      hlen_in = hlen_ff;
      present_in = present_ff;
      cur_in = cur_ff;
      chain_in = chain_ff;
      flag_in = flag_ff;
      freq_in = freq_ff;
      sig_in = sig_ff;
      noise_in = noise_ff;
      seen_in = seen_ff;
      over_in = over_ff;

      px = XW'(pos_ff);
      cx = XW'(cur_ff);
      c4 = cx + XW'(4);
      s_go = 1'b0;
      s_pend = 8'h00;
      s_cur = cx;
      pend = present_ff & ~seen_ff;
      fi = rtchp_pkg::lowest_field(pend);
      sz = rtchp_pkg::field_size(fi);
      off = 3'(px - cx);

      if (pos_ff < LENGTH_BITS'(4)) begin
         tag_in[{pos_ff[1:0], 3'b000} +: 8] = in_byte;
         if (pos_ff[1:0] == 2'd3) begin
            hlen_in = {16'h0000, in_byte, tag_ff[23:16]};
            if (hlen_in < 32'(rtchp_pkg::MIN_FRAME)) begin
               over_in = 1'b1;
            end
         end
      end else begin
         if (link_type == rtchp_pkg::LINK_PRISM && pos_ff < LENGTH_BITS'(8)) begin
            if (pos_ff[1:0] == 2'd0) begin
               hlen_in = {24'h000000, in_byte};
            end else begin
               hlen_in = hlen_ff | (32'(in_byte) << {pos_ff[1:0], 3'b000});
            end
         end
         if (!over_ff) begin
            if (chain_ff) begin
               if (px >= cx && px < c4) begin
                  if (pos_ff == LENGTH_BITS'(rtchp_pkg::PRESENT_START)) begin
                     present_in = in_byte;
                  end
                  if (px == cx + XW'(3)) begin
                     if (in_byte[rtchp_pkg::PRESENT_CHAIN]) begin
                        cur_in = CW'(c4);
                        if (c4 + XW'(4) > XW'(hlen_in)) begin
                           over_in = 1'b1;
                        end
                     end else begin
                        chain_in = 1'b0;
                        s_go = 1'b1;
                        s_pend = pend;
                        s_cur = c4;
                     end
                  end
               end
            end else if (pend != 8'h00 && px >= cx && px < cx + XW'(sz)) begin
               if (fi == rtchp_pkg::FIELD_FLAGS) begin
                  flag_in = in_byte;
               end else if (fi == rtchp_pkg::FIELD_CHANNEL && off == 3'd0) begin
                  freq_in = {8'h00, in_byte};
               end else if (fi == rtchp_pkg::FIELD_CHANNEL && off == 3'd1) begin
                  freq_in = freq_ff | {in_byte, 8'h00};
               end else if (fi == rtchp_pkg::FIELD_SIGNAL) begin
                  sig_in = in_byte;
               end else if (fi == rtchp_pkg::FIELD_NOISE) begin
                  noise_in = in_byte;
               end
               if (4'(off) + 4'd1 == sz) begin
                  seen_in = seen_ff | (8'h01 << fi);
                  s_go = 1'b1;
                  s_pend = pend & ~(8'h01 << fi);
                  s_cur = cx + XW'(sz);
               end
            end
         end
      end

      sj = rtchp_pkg::lowest_field(s_pend);
      amask = rtchp_pkg::field_align_mask(sj);
      al = (s_cur + XW'(amask)) & ~XW'(amask);
      if (s_go) begin
         if (s_pend == 8'h00) begin
            cur_in = CW'(s_cur);
         end else if (al + XW'(rtchp_pkg::field_size(sj)) > XW'(hlen_in)) begin
            over_in = 1'b1;
            cur_in = CW'(s_cur);
         end else begin
            cur_in = CW'(al);
         end
      end

      pos_in = (pos_ff == MAXPOS) ? pos_ff : pos_ff + LENGTH_BITS'(1);
   end

   assign push = accept && in_last;

   always_comb begin
      push_rec.link_type = link_type;
      push_rec.len = LW'(pos_in);
      push_rec.hlen = hlen_in;
      push_rec.tag_prism = (tag_in == rtchp_pkg::PRISM_TAG);
      push_rec.tag_low_zero = (tag_in[7:0] == 8'h00);
      push_rec.overrun = over_in;
      push_rec.flags_done = seen_in[rtchp_pkg::FIELD_FLAGS];
      push_rec.chan_seen = seen_in[rtchp_pkg::FIELD_CHANNEL];
      push_rec.sig_seen = seen_in[rtchp_pkg::FIELD_SIGNAL];
      push_rec.noise_seen = seen_in[rtchp_pkg::FIELD_NOISE];
      push_rec.flag_byte = flag_in;
      push_rec.freq = freq_in;
      push_rec.sig = sig_in;
      push_rec.noise = noise_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff <= '0;
         tag_ff <= '0;
         hlen_ff <= '0;
         present_ff <= '0;
         cur_ff <= CW'(rtchp_pkg::PRESENT_START);
         chain_ff <= 1'b1;
         flag_ff <= '0;
         freq_ff <= '0;
         sig_ff <= '0;
         noise_ff <= '0;
         seen_ff <= '0;
         over_ff <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         tag_ff <= tag_in;
         hlen_ff <= hlen_in;
         present_ff <= present_in;
         cur_ff <= cur_in;
         chain_ff <= chain_in;
         flag_ff <= flag_in;
         freq_ff <= freq_in;
         sig_ff <= sig_in;
         noise_ff <= noise_in;
         seen_ff <= seen_in;
         over_ff <= over_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cur_ff >= CW'(rtchp_pkg::PRESENT_START))
      else $error("Field cursor fell below the first present word.");

   assert property (@(posedge clock) disable iff (reset)
      (over_ff && !push) |=> over_ff)
      else $error("Overrun cleared before the frame ended.");

   assert property (@(posedge clock) disable iff (reset)
      (!chain_ff && !push) |=> !chain_ff)
      else $error("Present chain reopened within a frame.");

endmodule

>>> rtl/rtchp_queue.sv
module rtchp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rtchp_pkg::frame_rec_type  push_rec,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output rtchp_pkg::frame_rec_type  pop_rec
);

   localparam int DEPTH = rtchp_pkg::QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   rtchp_pkg::frame_rec_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec = slot_ff[rd_ptr_ff];
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Frame record written into a full queue.");

endmodule

>>> rtl/rtchp_back.sv
module rtchp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rec_valid,
   input  rtchp_pkg::frame_rec_type  rec,
   output logic                      rec_pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rtchp_pkg::result_type     out_res
);

   typedef struct packed {
      rtchp_pkg::status_type status;
      logic [15:0]           payload_offset;
      logic [15:0]           payload_length;
      logic [7:0]            signal_dbm;
      logic [7:0]            noise_dbm;
      logic [2:0]            unknown_flag_bits;
      logic                  fcs_stripped;
      logic                  ch_go;
      logic                  ch_known;
      logic                  ch_neg;
      logic [7:0]            ch_mag;
      logic [7:0]            ch_base;
   } stage_a_type;

   stage_a_type            a_ff, a_in;
   logic                   a_valid_ff;
   logic                   out_valid_ff;
   rtchp_pkg::result_type  res_ff, res_in;
   logic                   a_adv;
   logic                   b_adv;

   assign b_adv = !out_valid_ff || out_ready;
   assign a_adv = !a_valid_ff || b_adv;
   assign rec_pop = rec_valid && a_adv;

   always_comb begin
      logic [31:0] lenx;
      logic [15:0] f;

      a_in = '0;
      a_in.status = rtchp_pkg::ST_UNKNOWN;
      lenx = rec.len;
      f = rec.freq;

      unique case (rec.link_type)
         rtchp_pkg::LINK_ETHERNET: begin
            a_in.status = rtchp_pkg::ST_ETHERNET;
            a_in.payload_length = rec.len[15:0];
         end
         rtchp_pkg::LINK_WIFI: begin
            a_in.status = rtchp_pkg::ST_WIFI;
            a_in.payload_length = rec.len[15:0];
         end
         rtchp_pkg::LINK_PRISM: begin
            if (rec.len < 32'(rtchp_pkg::MIN_FRAME) || !rec.tag_prism ||
                rec.hlen >= rec.len) begin
               a_in.status = rtchp_pkg::ST_PRISM_BAD;
            end else begin
               a_in.status = rtchp_pkg::ST_WIFI;
               a_in.payload_offset = rec.hlen[15:0];
               a_in.payload_length = rec.len[15:0] - rec.hlen[15:0];
            end
         end
         rtchp_pkg::LINK_RADIOTAP: begin
            if (rec.len < 32'(rtchp_pkg::MIN_FRAME)) begin
               a_in.status = rtchp_pkg::ST_SHORT;
            end else if (!rec.tag_low_zero || rec.hlen >= rec.len) begin
               a_in.status = rtchp_pkg::ST_CORRUPT;
            end else if (rec.overrun && !rec.flags_done) begin
               a_in.status = rtchp_pkg::ST_TRUNCATED;
            end else begin
               a_in.status = rtchp_pkg::ST_WIFI;
               if (rec.flags_done) begin
                  a_in.unknown_flag_bits = 3'(rec.flag_byte[0]) + 3'(rec.flag_byte[2]) +
                                           3'(rec.flag_byte[3]);
                  if (rec.flag_byte[rtchp_pkg::FLAG_FCS_PRESENT]) begin
                     a_in.fcs_stripped = 1'b1;
                     lenx = rec.len - 32'(rtchp_pkg::FCS_BYTES);
                     if (rec.hlen >= lenx) begin
                        a_in.status = rtchp_pkg::ST_CORRUPT;
                     end
                  end
                  if (a_in.status == rtchp_pkg::ST_WIFI) begin
                     a_in.unknown_flag_bits = a_in.unknown_flag_bits + 3'(rec.flag_byte[5]);
                     if (rec.flag_byte[rtchp_pkg::FLAG_BAD_FCS]) begin
                        a_in.status = rtchp_pkg::ST_FCS_ERROR;
                     end else begin
                        a_in.unknown_flag_bits = a_in.unknown_flag_bits +
                                                 3'(rec.flag_byte[7]);
                     end
                  end
               end
               if (a_in.status == rtchp_pkg::ST_WIFI && rec.overrun) begin
                  a_in.status = rtchp_pkg::ST_TRUNCATED;
               end
               if (a_in.status == rtchp_pkg::ST_WIFI) begin
                  a_in.payload_offset = rec.hlen[15:0];
                  a_in.payload_length = lenx[15:0] - rec.hlen[15:0];
                  a_in.ch_go = rec.chan_seen;
                  a_in.signal_dbm = rec.sig_seen ? rec.sig : 8'h00;
                  a_in.noise_dbm = rec.noise_seen ? rec.noise : 8'h00;
               end
            end
         end
         default: begin
            a_in.status = rtchp_pkg::ST_UNKNOWN;
         end
      endcase

      a_in.ch_known = 1'b1;
      if (f >= rtchp_pkg::FREQ_BG_LOW && f <= rtchp_pkg::FREQ_BG_HIGH) begin
         a_in.ch_neg = (f < rtchp_pkg::FREQ_BG_BASE);
         a_in.ch_mag = a_in.ch_neg ? 8'(rtchp_pkg::FREQ_BG_BASE - f) :
                                     8'(f - rtchp_pkg::FREQ_BG_BASE);
         a_in.ch_base = rtchp_pkg::CHAN_BG_BASE;
      end else if (f == rtchp_pkg::FREQ_CH14) begin
         a_in.ch_base = rtchp_pkg::CHAN_14;
      end else if (f >= rtchp_pkg::FREQ_A_LOW && f <= rtchp_pkg::FREQ_A_HIGH) begin
         a_in.ch_mag = 8'(f - rtchp_pkg::FREQ_A_LOW);
         a_in.ch_base = rtchp_pkg::CHAN_A_BASE;
      end else if (f >= rtchp_pkg::FREQ_B_LOW && f <= rtchp_pkg::FREQ_B_HIGH) begin
         a_in.ch_mag = 8'(f - rtchp_pkg::FREQ_B_LOW);
         a_in.ch_base = rtchp_pkg::CHAN_B_BASE;
      end else if (f > rtchp_pkg::FREQ_B_HIGH && f <= rtchp_pkg::FREQ_C_HIGH) begin
         a_in.ch_mag = 8'(f - rtchp_pkg::FREQ_B_HIGH);
         a_in.ch_base = rtchp_pkg::CHAN_C_BASE;
      end else begin
         a_in.ch_known = 1'b0;
      end
   end

   always_comb begin
      logic [15:0] prod;
      logic [8:0]  quot;

      prod = 16'(a_ff.ch_mag) * rtchp_pkg::DIV5_RECIP;
      quot = 9'(prod >> rtchp_pkg::DIV5_SHIFT);

      res_in.status = a_ff.status;
      res_in.payload_offset = a_ff.payload_offset;
      res_in.payload_length = a_ff.payload_length;
      res_in.signal_dbm = a_ff.signal_dbm;
      res_in.noise_dbm = a_ff.noise_dbm;
      res_in.unknown_flag_bits = a_ff.unknown_flag_bits;
      res_in.fcs_stripped = a_ff.fcs_stripped;
      if (!a_ff.ch_go) begin
         res_in.channel = 9'sd0;
      end else if (!a_ff.ch_known) begin
         res_in.channel = -9'sd1;
      end else if (a_ff.ch_neg) begin
         res_in.channel = $signed(9'(a_ff.ch_base) - quot);
      end else begin
         res_in.channel = $signed(9'(a_ff.ch_base) + quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= rec_valid;
         end
         if (b_adv) begin
            out_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         a_ff <= a_in;
      end
      if (a_valid_ff && b_adv) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res = res_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.status == rtchp_pkg::ST_UNKNOWN) |->
      (res_ff.payload_offset == 16'h0000 && res_ff.payload_length == 16'h0000 &&
       res_ff.channel == 9'sd0 && res_ff.unknown_flag_bits == 3'd0))
      else $error("Unknown link type result carries nonzero fields.");

   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_adv) |=> (a_valid_ff && $stable(a_ff)))
      else $error("First back stage lost or changed a held record.");

endmodule

>>> rtl/radiotap_capture_header_parser_core.sv
// Accepts one capture byte per cycle while the queue is not full, with no gaps between frames.
// After its last byte is accepted, a frame's record passes through the frame record queue,
// the first back stage (status decode) and the result register (channel divide, result word).
// Results leave at up to one per cycle; a two-entry queue absorbs output stalls.
// Reset clears the frame state, empties the queue and sets the link type to radiotap.
module radiotap_capture_header_parser_core #(
   parameter int LENGTH_BITS = rtchp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // payload_offset, payload_length,
                                                            // channel, signal_dbm, noise_dbm,
                                                            // unknown_flag_bits, fcs_stripped
   output logic [2:0]                          rsp_tuser,   // status
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rtchp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [7:0]               link_ff;
   logic                     csr_hit;
   logic                     queue_full;
   logic                     push;
   rtchp_pkg::frame_rec_type push_rec;
   logic                     pop;
   logic                     pop_valid;
   rtchp_pkg::frame_rec_type pop_rec;
   rtchp_pkg::result_type    res;

   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[rtchp_pkg::CSR_ADDR_W-1] == rtchp_pkg::REG_LINK_TYPE);
   assign csr_prdata = csr_hit ? {24'h000000, link_ff} : 32'h0000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= rtchp_pkg::LINK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         link_ff <= csr_pwdata[7:0];
      end
   end

   rtchp_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_byte(req_tdata),
      .in_last(req_tlast),
      .link_type(link_ff),
      .queue_full(queue_full),
      .push(push),
      .push_rec(push_rec)
   );

   rtchp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_rec(push_rec),
      .full(queue_full),
      .pop(pop),
      .pop_valid(pop_valid),
      .pop_rec(pop_rec)
   );

   rtchp_back u_back (
      .clock(clock),
      .reset(reset),
      .rec_valid(pop_valid),
      .rec(pop_rec),
      .rec_pop(pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_res(res)
   );

   assign rsp_tuser = res.status;
   assign rsp_tdata = {3'b000, res.fcs_stripped, res.unknown_flag_bits, res.noise_dbm,
                       res.signal_dbm, res.channel, res.payload_length, res.payload_offset};

endmodule
